### rtl/rsc_pkg.sv
// Shared types and constants of the reference-counting sweep collector.
`default_nettype none
package rsc_pkg;

	localparam int KIND_W   = 2;
	localparam int SLOT_FW  = 3;
	localparam int EIDX_FW  = 2;
	localparam int STATUS_W = 3;
	localparam int MASK_W   = 8;
	localparam int COUNT_W  = 6;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_EDGE    = 2'd1,
		KIND_ROOT    = 2'd2,
		KIND_COLLECT = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_OCCUPIED = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_EDGE_SET = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_OP   = 8'b0000_0010,
		S_EXE  = 8'b0000_0100,
		S_SCAN = 8'b0000_1000,
		S_CHK  = 8'b0001_0000,
		S_REL  = 8'b0010_0000,
		S_DEC  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

endpackage
`default_nettype wire

### rtl/rsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/refcount_sweep_collector_core.sv
// Top level of the reference-counting sweep collector.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tuser kind, tdata slot/edge_index/target
//  m_       out  m_tvalid/m_tready    tdata status/freed_mask
//
// Allocate, set edge and root: read (S_OP), modify and write (S_EXE), output (S_DONE); the next
// beat is taken once the result has moved into the output register.
// Collect: each pass reads every slot's count (S_SCAN, S_CHK); a freed slot then walks its EDGES_PER_NODE
// edge entries, with one count read-modify-write per valid edge; passes = freeing passes + 1.
// Reset clears the in-use bits but not the count and edge RAMs; those are rewritten on allocate.
// A result waits in the output register; the next beat is accepted meanwhile, and a
// finished item holds in its done state while the output is still full.
`default_nettype none
module refcount_sweep_collector_core #(
	parameter int SLOTS          = 8,
	parameter int EDGES_PER_NODE = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // slot[2:0], edge_index[4:3], target[7:5]
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata    // status[2:0], freed_mask[10:3], zero[15:11]
);

	localparam int SW    = $clog2(SLOTS);
	localparam int EW    = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
	localparam int ENT   = SW + 1;
	localparam int ROW_W = EDGES_PER_NODE * ENT;

	rsc_pkg::state_t  state_q;
	rsc_pkg::kind_t   kind_q;
	logic [rsc_pkg::SLOT_FW-1:0] slot_q;
	logic [rsc_pkg::EIDX_FW-1:0] eidx_q;
	logic [rsc_pkg::SLOT_FW-1:0] tgt_q;
	logic [SLOTS-1:0]            in_use_q;
	logic [SW-1:0]               i_q;
	logic [EW-1:0]               e_q;
	logic [ROW_W-1:0]            row_q;
	logic [SW-1:0]               dtgt_q;
	logic                        freed_q;
	logic [rsc_pkg::MASK_W-1:0]  mask_q;
	rsc_pkg::status_t            res_status_q;
	logic                        m_tvalid_q;
	rsc_pkg::status_t            m_status_q;
	logic [rsc_pkg::MASK_W-1:0]  m_mask_q;

	logic                        cnt_we;
	logic [SW-1:0]               cnt_waddr;
	logic [rsc_pkg::COUNT_W-1:0] cnt_wdata;
	logic [SW-1:0]               cnt_raddr;
	logic [rsc_pkg::COUNT_W-1:0] cnt_rd;
	logic                        edg_we;
	logic [SW-1:0]               edg_raddr;
	logic [ROW_W-1:0]            edg_wdata;
	logic [ROW_W-1:0]            erow;
	logic [ROW_W-1:0]            erow_new;

	logic [SW-1:0]               s_idx;
	logic [SW-1:0]               t_idx;
	logic [EW-1:0]               e_sel;
	logic                        s_in_range;
	logic                        s_live;
	logic                        t_live;
	logic                        e_ok;
	logic                        evalid;
	rsc_pkg::status_t            op_status;
	logic                        row_valid;
	logic [SW-1:0]               row_tgt;
	logic                        last_e;
	logic                        last_i;
	logic                        cand;
	logic                        freeing;
	logic                        slot_end;
	logic                        any_freed;
	logic [rsc_pkg::MASK_W-1:0]  live_low;

	rsc_ram #(.WIDTH(rsc_pkg::COUNT_W), .DEPTH(SLOTS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rd)
	);

	rsc_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_edge_ram (
		.clk   (clk),
		.we    (edg_we),
		.waddr (s_idx),
		.wdata (edg_wdata),
		.raddr (edg_raddr),
		.rdata (erow)
	);

	assign s_idx      = SW'(slot_q);
	assign t_idx      = SW'(tgt_q);
	assign e_sel      = EW'(eidx_q);
	assign s_in_range = 32'(slot_q) < SLOTS;
	assign s_live     = s_in_range && in_use_q[s_idx];
	assign t_live     = (32'(tgt_q) < SLOTS) && in_use_q[t_idx];
	assign e_ok       = 32'(eidx_q) < EDGES_PER_NODE;
	assign evalid     = erow[32'(e_sel) * ENT + SW];

	assign row_valid = row_q[32'(e_q) * ENT + SW];
	assign row_tgt   = row_q[32'(e_q) * ENT +: SW];
	assign last_e    = e_q == EW'(EDGES_PER_NODE - 1);
	assign last_i    = i_q == SW'(SLOTS - 1);
	assign cand      = in_use_q[i_q] && (cnt_rd == '0);

	always_comb begin
		op_status = rsc_pkg::ST_OK;
		unique case (kind_q)
			rsc_pkg::KIND_ALLOC: begin
				priority if (!s_in_range) op_status = rsc_pkg::ST_EMPTY;
				else if (in_use_q[s_idx]) op_status = rsc_pkg::ST_OCCUPIED;
				else                      op_status = rsc_pkg::ST_OK;
			end
			rsc_pkg::KIND_EDGE: begin
				priority if (!s_live || !t_live)        op_status = rsc_pkg::ST_EMPTY;
				else if (!e_ok)                         op_status = rsc_pkg::ST_EDGE_SET;
				else if (evalid)                        op_status = rsc_pkg::ST_EDGE_SET;
				else if (cnt_rd >= rsc_pkg::COUNT_MAX)  op_status = rsc_pkg::ST_OVERFLOW;
				else                                    op_status = rsc_pkg::ST_OK;
			end
			rsc_pkg::KIND_ROOT: begin
				priority if (!s_live)                   op_status = rsc_pkg::ST_EMPTY;
				else if (cnt_rd >= rsc_pkg::COUNT_MAX)  op_status = rsc_pkg::ST_OVERFLOW;
				else                                    op_status = rsc_pkg::ST_OK;
			end
			rsc_pkg::KIND_COLLECT: begin
				op_status = rsc_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		erow_new = erow;
		erow_new[32'(e_sel) * ENT +: ENT] = {1'b1, t_idx};
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = s_idx;
		cnt_wdata = '0;
		edg_we    = 1'b0;
		edg_wdata = '0;
		cnt_raddr = i_q;
		edg_raddr = (state_q == rsc_pkg::S_OP) ? s_idx : i_q;
		unique case (state_q)
			rsc_pkg::S_OP: begin
				cnt_raddr = (kind_q == rsc_pkg::KIND_ROOT) ? s_idx : t_idx;
			end
			rsc_pkg::S_EXE: begin
				if (op_status == rsc_pkg::ST_OK) begin
					unique case (kind_q)
						rsc_pkg::KIND_ALLOC: begin
							cnt_we = 1'b1;
							edg_we = 1'b1;
						end
						rsc_pkg::KIND_EDGE: begin
							cnt_we    = 1'b1;
							cnt_waddr = t_idx;
							cnt_wdata = rsc_pkg::COUNT_W'(cnt_rd + 1'b1);
							edg_we    = 1'b1;
							edg_wdata = erow_new;
						end
						rsc_pkg::KIND_ROOT: begin
							cnt_we    = 1'b1;
							cnt_wdata = rsc_pkg::COUNT_W'(cnt_rd + 1'b1);
						end
						rsc_pkg::KIND_COLLECT: begin
						end
					endcase
				end
			end
			rsc_pkg::S_REL: begin
				cnt_raddr = row_tgt;
			end
			rsc_pkg::S_DEC: begin
				cnt_waddr = dtgt_q;
				cnt_wdata = rsc_pkg::COUNT_W'(cnt_rd - 1'b1);
				cnt_we    = in_use_q[dtgt_q] && (cnt_rd != '0);
			end
			rsc_pkg::S_IDLE, rsc_pkg::S_SCAN, rsc_pkg::S_CHK, rsc_pkg::S_DONE: begin
			end
		endcase
	end

	assign freeing   = ((state_q == rsc_pkg::S_REL) && !row_valid && last_e) ||
	                   ((state_q == rsc_pkg::S_DEC) && last_e);
	assign slot_end  = ((state_q == rsc_pkg::S_CHK) && !cand) || freeing;
	assign any_freed = freed_q || freeing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rsc_pkg::S_IDLE;
			kind_q       <= rsc_pkg::KIND_ALLOC;
			slot_q       <= '0;
			eidx_q       <= '0;
			tgt_q        <= '0;
			in_use_q     <= '0;
			i_q          <= '0;
			e_q          <= '0;
			row_q        <= '0;
			dtgt_q       <= '0;
			freed_q      <= 1'b0;
			mask_q       <= '0;
			res_status_q <= rsc_pkg::ST_OK;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= rsc_pkg::ST_OK;
			m_mask_q     <= '0;
		end else begin
			if (m_tready && state_q != rsc_pkg::S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				rsc_pkg::S_IDLE: begin
					if (s_tvalid) begin
						kind_q <= rsc_pkg::kind_t'(s_tuser);
						slot_q <= s_tdata[2:0];
						eidx_q <= s_tdata[4:3];
						tgt_q  <= s_tdata[7:5];
						if (rsc_pkg::kind_t'(s_tuser) == rsc_pkg::KIND_COLLECT) begin
							i_q     <= '0;
							freed_q <= 1'b0;
							mask_q  <= '0;
							state_q <= rsc_pkg::S_SCAN;
						end else begin
							state_q <= rsc_pkg::S_OP;
						end
					end
				end
				rsc_pkg::S_OP: begin
					state_q <= rsc_pkg::S_EXE;
				end
				rsc_pkg::S_EXE: begin
					res_status_q <= op_status;
					mask_q       <= '0;
					if (kind_q == rsc_pkg::KIND_ALLOC && op_status == rsc_pkg::ST_OK) begin
						in_use_q[s_idx] <= 1'b1;
					end
					state_q <= rsc_pkg::S_DONE;
				end
				rsc_pkg::S_SCAN: begin
					state_q <= rsc_pkg::S_CHK;
				end
				rsc_pkg::S_CHK: begin
					if (cand) begin
						row_q   <= erow;
						e_q     <= '0;
						state_q <= rsc_pkg::S_REL;
					end
				end
				rsc_pkg::S_REL: begin
					if (row_valid) begin
						dtgt_q  <= row_tgt;
						state_q <= rsc_pkg::S_DEC;
					end else if (!last_e) begin
						e_q <= EW'(e_q + 1'b1);
					end
				end
				rsc_pkg::S_DEC: begin
					if (!last_e) begin
						e_q     <= EW'(e_q + 1'b1);
						state_q <= rsc_pkg::S_REL;
					end
				end
				rsc_pkg::S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_mask_q   <= mask_q;
						state_q    <= rsc_pkg::S_IDLE;
					end
				end
			endcase

			if (freeing) begin
				in_use_q[i_q] <= 1'b0;
				if (!last_i) begin
					freed_q <= 1'b1;
				end
				if (32'(i_q) < rsc_pkg::MASK_W) begin
					mask_q[3'(i_q)] <= 1'b1;
				end
			end
			if (slot_end) begin
				priority if (!last_i) begin
					i_q     <= SW'(i_q + 1'b1);
					state_q <= rsc_pkg::S_SCAN;
				end else if (any_freed) begin
					i_q     <= '0;
					freed_q <= 1'b0;
					state_q <= rsc_pkg::S_SCAN;
				end else begin
					res_status_q <= rsc_pkg::ST_OK;
					state_q      <= rsc_pkg::S_DONE;
				end
			end
		end
	end

	always_comb begin
		for (int b = 0; b < rsc_pkg::MASK_W; b++) begin
			live_low[b] = (b < SLOTS) ? in_use_q[SW'(b)] : 1'b0;
		end
	end

	assign s_tready = state_q == rsc_pkg::S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, m_mask_q, m_status_q};

`ifndef SYNTHESIS
	a_err_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_status_q != rsc_pkg::ST_OK) |-> (m_mask_q == '0))
		else $error("error status with nonzero freed mask");

	a_freed_not_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsc_pkg::S_DONE && kind_q == rsc_pkg::KIND_COLLECT)
		|-> ((mask_q & live_low) == '0))
		else $error("slot in freed mask still in use");

	a_inc_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsc_pkg::S_EXE && kind_q != rsc_pkg::KIND_ALLOC && cnt_we)
		|-> (cnt_wdata == rsc_pkg::COUNT_W'(cnt_rd + 1'b1)))
		else $error("count write is not an increment");

	a_dec_follows_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsc_pkg::S_DEC) |-> ($past(state_q) == rsc_pkg::S_REL && $past(row_valid)))
		else $error("release step without a valid edge");
`endif

endmodule
`default_nettype wire

### verif/tb_refcount_sweep_collector_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the refcount sweep collector: directed and random ops, per-beat reply check.
module tb_refcount_sweep_collector_core;
	import rsc_pkg::*;

	localparam int NSLOT           = 8;
	localparam int NEDGE           = 3;
	localparam int ITEMS_PER_PHASE = 380;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_CYCLES     = 250;
	localparam int SETTLE_CYCLES   = 64;
	localparam int RANK_TOP        = 1001;
	localparam logic [2:0] PINNED  = 3'd7;

	typedef struct packed {
		status_t           status;
		logic [MASK_W-1:0] freed;
	} reply_t;

	class collector_scoreboard;
		bit                 in_use[NSLOT];
		logic [COUNT_W-1:0] refs[NSLOT];
		bit                 link_valid[NSLOT*NEDGE];
		logic [2:0]         link_target[NSLOT*NEDGE];
		reply_t             expected_replies[$];
		int                 mismatches;

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				in_use[i] = 1'b0;
				refs[i]   = '0;
			end
			for (int i = 0; i < NSLOT*NEDGE; i++) begin
				link_valid[i]  = 1'b0;
				link_target[i] = '0;
			end
			mismatches = 0;
		endfunction

		function reply_t apply_op(kind_t k, logic [2:0] s, logic [1:0] ei, logic [2:0] t);
			reply_t r;
			int pos;
			bit progress;
			r.status = ST_OK;
			r.freed  = '0;
			case (k)
				KIND_ALLOC: begin
					if (in_use[s]) begin
						r.status = ST_OCCUPIED;
					end else begin
						in_use[s] = 1'b1;
						refs[s]   = '0;
						for (int e = 0; e < NEDGE; e++)
							link_valid[int'(s)*NEDGE+e] = 1'b0;
					end
				end
				KIND_EDGE: begin
					if (!in_use[s] || !in_use[t]) begin
						r.status = ST_EMPTY;
					end else if (int'(ei) >= NEDGE) begin
						r.status = ST_EDGE_SET;
					end else begin
						pos = int'(s)*NEDGE + int'(ei);
						if (link_valid[pos]) begin
							r.status = ST_EDGE_SET;
						end else if (refs[t] == COUNT_MAX) begin
							r.status = ST_OVERFLOW;
						end else begin
							link_valid[pos]  = 1'b1;
							link_target[pos] = t;
							refs[t]          = refs[t] + 1'b1;
						end
					end
				end
				KIND_ROOT: begin
					if (!in_use[s])
						r.status = ST_EMPTY;
					else if (refs[s] == COUNT_MAX)
						r.status = ST_OVERFLOW;
					else
						refs[s] = refs[s] + 1'b1;
				end
				default: begin
					progress = 1'b1;
					while (progress) begin
						progress = 1'b0;
						for (int i = 0; i < NSLOT; i++) begin
							if (in_use[i] && refs[i] == 0) begin
								for (int e = 0; e < NEDGE; e++) begin
									pos = i*NEDGE + e;
									if (link_valid[pos]) begin
										if (in_use[link_target[pos]] && refs[link_target[pos]] != 0)
											refs[link_target[pos]] = refs[link_target[pos]] - 1'b1;
										link_valid[pos] = 1'b0;
									end
								end
								in_use[i]  = 1'b0;
								r.freed[i] = 1'b1;
								progress   = 1'b1;
							end
						end
					end
				end
			endcase
			return r;
		endfunction

		function void note_op(kind_t k, logic [2:0] s, logic [1:0] ei, logic [2:0] t);
			expected_replies.push_back(apply_op(k, s, ei, t));
		endfunction

		function void check_reply(logic [15:0] d);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with none pending, actual %h", $time, d);
				mismatches++;
				return;
			end
			want = expected_replies.pop_front();
			if (d[2:0] !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, d[2:0]);
				mismatches++;
			end
			if (d[10:3] !== want.freed) begin
				$display("%0t: freed_mask expected %h actual %h", $time, want.freed, d[10:3]);
				mismatches++;
			end
			if (d[15:11] !== 5'd0) begin
				$display("%0t: pad bits expected 0 actual %h", $time, d[15:11]);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;

	collector_scoreboard sb;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int hold_req     = 0;
	int hold_left    = 0;
	int beats_sent   = 0;
	int quiet_cycles = 0;
	int slot_rank[NSLOT];

	refcount_sweep_collector_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req > 0) begin
				m_tready  <= 1'b0;
				hold_left = hold_req - 1;
				hold_req  = 0;
			end else begin
				m_tready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			sb.check_reply(m_tdata);
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_beat(kind_t k, logic [2:0] s, logic [1:0] ei, logic [2:0] t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {t, ei, s};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		sb.note_op(k, s, ei, t);
		beats_sent++;
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [2:0] choose_alloc_slot();
		logic [2:0] free_slots[$];
		if ($urandom_range(3) != 0) begin
			for (int i = 0; i < NSLOT; i++)
				if (!sb.in_use[i])
					free_slots.push_back(3'(i));
			if (free_slots.size() != 0)
				return free_slots[$urandom_range(free_slots.size() - 1)];
		end
		return 3'($urandom_range(7));
	endfunction

	// ranks keep well-formed edges acyclic so unrooted graphs stay collectible
	function automatic bit choose_link(output logic [2:0] src, output logic [2:0] dst);
		logic [2:0] a;
		logic [2:0] b;
		src = '0;
		dst = '0;
		for (int tries = 0; tries < 12; tries++) begin
			a = 3'($urandom_range(6));
			b = 3'($urandom_range(7));
			if (sb.in_use[a] && sb.in_use[b] && slot_rank[a] < slot_rank[b]) begin
				src = a;
				dst = b;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic send_random_collect();
		send_beat(KIND_COLLECT, 3'($urandom_range(7)), 2'($urandom_range(3)),
			3'($urandom_range(7)));
	endtask

	task automatic build_round();
		int n_alloc;
		int n_link;
		logic [2:0] s;
		logic [2:0] t;
		logic [1:0] ei;
		n_alloc = $urandom_range(1, 3);
		n_link  = $urandom_range(0, 4);
		repeat (n_alloc) begin
			s = choose_alloc_slot();
			if (!sb.in_use[s] && s != PINNED)
				slot_rank[s] = $urandom_range(0, RANK_TOP - 1);
			send_beat(KIND_ALLOC, s, 2'($urandom_range(3)), 3'($urandom_range(7)));
		end
		repeat (n_link) begin
			if (choose_link(s, t)) begin
				ei = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
				send_beat(KIND_EDGE, s, ei, t);
			end
		end
		if ($urandom_range(1) == 1)
			send_random_collect();
	endtask

	task automatic root_round();
		logic [2:0] s;
		s = PINNED;
		if ($urandom_range(2) == 0)
			s = 3'($urandom_range(7));
		if (sb.in_use[s] && s != PINNED)
			s = PINNED;
		send_beat(KIND_ROOT, s, 2'($urandom_range(3)), 3'($urandom_range(7)));
	endtask

	// drive the pinned slot to the count ceiling, then overflow it by root and by edge
	task automatic saturate_pinned();
		int src;
		int pos;
		if (!sb.in_use[PINNED])
			return;
		while (sb.refs[PINNED] != COUNT_MAX)
			send_beat(KIND_ROOT, PINNED, 2'd0, 3'd0);
		send_beat(KIND_ROOT, PINNED, 2'd3, 3'd7);
		src = -1;
		pos = 0;
		for (int i = 0; i < NSLOT - 1 && src < 0; i++) begin
			if (!sb.in_use[i]) begin
				src = i;
			end else begin
				for (int e = 0; e < NEDGE && src < 0; e++)
					if (!sb.link_valid[i*NEDGE+e]) begin
						src = i;
						pos = e;
					end
			end
		end
		if (src < 0)
			return;
		if (!sb.in_use[src]) begin
			slot_rank[src] = 0;
			send_beat(KIND_ALLOC, 3'(src), 2'd0, 3'd0);
		end
		send_beat(KIND_EDGE, 3'(src), 2'(pos), PINNED);
	endtask

	task automatic run_random(int n_items, bit with_saturation);
		int start;
		int pick;
		start = beats_sent;
		if (with_saturation)
			saturate_pinned();
		while (beats_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55)
				build_round();
			else if (pick < 78)
				send_random_collect();
			else if (pick < 90)
				root_round();
			else
				send_beat(kind_t'($urandom_range(3)), 3'($urandom_range(7)),
					2'($urandom_range(3)), 3'($urandom_range(7)));
		end
	endtask

	task automatic run_directed();
		send_beat(KIND_COLLECT, 3'd0, 2'd0, 3'd0);
		send_beat(KIND_ROOT,    3'd0, 2'd0, 3'd0);
		send_beat(KIND_EDGE,    3'd0, 2'd0, 3'd7);
		send_beat(KIND_ALLOC,   3'd0, 2'd0, 3'd0);
		send_beat(KIND_ALLOC,   3'd7, 2'd3, 3'd7);
		send_beat(KIND_ALLOC,   3'd0, 2'd0, 3'd0);
		send_beat(KIND_EDGE,    3'd0, 2'd0, 3'd5);
		send_beat(KIND_EDGE,    3'd0, 2'd3, 3'd7);
		send_beat(KIND_EDGE,    3'd0, 2'd0, 3'd7);
		send_beat(KIND_EDGE,    3'd0, 2'd0, 3'd7);
		send_beat(KIND_EDGE,    3'd7, 2'd2, 3'd7);
		send_beat(KIND_ROOT,    3'd7, 2'd0, 3'd0);
		send_beat(KIND_ALLOC,   3'd4, 2'd0, 3'd0);
		send_beat(KIND_ALLOC,   3'd5, 2'd0, 3'd0);
		send_beat(KIND_EDGE,    3'd4, 2'd2, 3'd5);
		send_beat(KIND_ALLOC,   3'd6, 2'd0, 3'd0);
		send_beat(KIND_ALLOC,   3'd1, 2'd0, 3'd0);
		send_beat(KIND_EDGE,    3'd6, 2'd1, 3'd1);
		send_beat(KIND_EDGE,    3'd6, 2'd2, 3'd0);
		send_beat(KIND_COLLECT, 3'd7, 2'd3, 3'd7);
		send_beat(KIND_COLLECT, 3'd0, 2'd0, 3'd0);
		send_beat(KIND_ROOT,    3'd3, 2'd0, 3'd0);
	endtask

	initial begin
		sb = new();
		for (int i = 0; i < NSLOT; i++)
			slot_rank[i] = 0;
		slot_rank[PINNED] = RANK_TOP;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_for_replies();

		src_idle_pct = 16;
		dst_idle_pct = 46;
		run_random(ITEMS_PER_PHASE, 1'b0);
		wait_for_replies();

		src_idle_pct = 46;
		dst_idle_pct = 16;
		hold_req     = HOLD_CYCLES;
		run_random(ITEMS_PER_PHASE, 1'b1);

		src_idle_pct = 0;
		dst_idle_pct = 0;
		run_random(ITEMS_PER_PHASE, 1'b0);
		wait_for_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
